FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/itp_pkg.sv
package itp_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;
    localparam logic [1:0] ERR_BADCHAR   = 2'd3;

    localparam logic [1:0] RANK_OPEN = 2'd1;
    localparam logic [1:0] RANK_ADD  = 2'd2;
    localparam logic [1:0] RANK_MUL  = 2'd3;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP,
        CLS_NEWLINE,
        CLS_BAD
    } t_char_class;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_CHAR,
        SEL_TOP
    } t_emit_sel;

    typedef struct packed {
        logic        load_char;
        logic        emit;
        t_emit_sel   emit_sel;
        logic        emit_done;
        logic [1:0]  emit_err;
        logic        pop;
        logic        push;
        logic        release_last;
    } t_ctrl_cmd;

    typedef struct packed {
        t_char_class cls;
        logic        empty;
        logic        full;
        logic        top_open;
        logic        top_outranks;
        logic        slot_free;
        logic        pend_valid;
    } t_dp_status;

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class cls;
        cls = CLS_BAD;
        if (c == CH_SPACE) begin
            cls = CLS_SPACE;
        end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A)) begin
            cls = CLS_ALNUM;
        end else if (c == CH_OPEN) begin
            cls = CLS_OPEN;
        end else if (c == CH_CLOSE) begin
            cls = CLS_CLOSE;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                     c == CH_SLASH || c == CH_PERCENT) begin
            cls = CLS_OP;
        end else if (c == CH_NEWLINE) begin
            cls = CLS_NEWLINE;
        end
        return cls;
    endfunction

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        logic [1:0] r;
        r = RANK_OPEN;
        if (c == CH_PLUS || c == CH_MINUS) begin
            r = RANK_ADD;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PERCENT) begin
            r = RANK_MUL;
        end
        return r;
    endfunction

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// Shunting-yard infix to postfix converter taking one ASCII character per input
// transfer. Characters are handled one at a time: an accepted character is loaded in
// the idle state, evaluated in the evaluation state, and a closing state then sends
// the held final result, if any; each operator popped from the stack adds another
// evaluation step, as the stack memory read address follows the next stack count
// so the new top is ready in the following cycle. Output back-pressure stalls
// evaluation and closing while the output register holds an untaken result. Results
// of one character end with tlast; a newline flushes the stack and ends with a
// terminator carrying done_res. The operator stack needs no clearing after reset.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // in_char
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_char
    output logic       o_m_axis_tlast,
    output logic [2:0] o_m_axis_tuser    // done_res, error[1:0]
);
    import itp_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    itp_controller u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

FILE: rtl/itp_datapath.sv
`include "assert_macros.svh"

module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itp_pkg::t_ctrl_cmd   i_cmd,
    output itp_pkg::t_dp_status  o_status,
    input  logic [7:0]           i_s_axis_tdata,   // in_char
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // out_char
    output logic                 o_m_axis_tlast,
    output logic [2:0]           o_m_axis_tuser    // done_res, error[1:0]
);
    import itp_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    logic [7:0]       r_mem [STACK_DEPTH];
    logic [7:0]       r_char;
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] rd_cnt;
    logic [ADDR_W-1:0] rd_addr;

    logic [7:0]       r_pend_char;
    logic             r_pend_done;
    logic [1:0]       r_pend_err;
    logic             r_pend_valid;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             r_out_done;
    logic [1:0]       r_out_err;

    logic [7:0]       emit_char;
    logic             load_out;
    logic             slot_free;

    // next count drives the read address so the registered top is ready in the next cycle
    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        rd_cnt  = (n_count == '0) ? '0 : n_count - CNT_W'(1);
        rd_addr = rd_cnt[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_char;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_s_axis_tdata;
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            SEL_CHAR: emit_char = r_char;
            SEL_TOP:  emit_char = r_rd_data;
            default:  emit_char = CH_NUL;
        endcase
    end

    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign load_out  = (i_cmd.emit && r_pend_valid) || i_cmd.release_last;

    // one result is held back until it is known whether it ends the transfer run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.release_last) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend_char <= emit_char;
            r_pend_done <= i_cmd.emit_done;
            r_pend_err  <= i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_char <= r_pend_char;
            r_out_done <= r_pend_done;
            r_out_err  <= r_pend_err;
            r_out_last <= i_cmd.release_last;
        end
    end

    always_comb begin
        o_status.cls          = classify(r_char);
        o_status.empty        = (r_count == '0);
        o_status.full         = (r_count >= DEPTH_CNT);
        o_status.top_open     = (r_rd_data == CH_OPEN);
        o_status.top_outranks = (rank_of(r_rd_data) >= rank_of(r_char));
        o_status.slot_free    = slot_free;
        o_status.pend_valid   = r_pend_valid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = {r_out_err, r_out_done};

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_CNT)
    `ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, i_cmd.push, r_count < DEPTH_CNT)
    `ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_count != '0)
    `ASSERT_IMPLY(a_out_no_overwrite, i_clk, i_rst_n, load_out, slot_free)

endmodule

FILE: rtl/itp_controller.sv
`include "assert_macros.svh"

module itp_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  itp_pkg::t_dp_status  i_status,
    output itp_pkg::t_ctrl_cmd   o_cmd
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state             = r_state;
        o_cmd.load_char     = 1'b0;
        o_cmd.emit          = 1'b0;
        o_cmd.emit_sel      = SEL_NONE;
        o_cmd.emit_done     = 1'b0;
        o_cmd.emit_err      = ERR_NONE;
        o_cmd.pop           = 1'b0;
        o_cmd.push          = 1'b0;
        o_cmd.release_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load_char = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.slot_free) begin
                    case (i_status.cls)
                        CLS_SPACE: begin
                            n_state = S_FLUSH;
                        end
                        CLS_ALNUM: begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = SEL_CHAR;
                            n_state        = S_FLUSH;
                        end
                        CLS_OPEN: begin
                            if (i_status.full) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_err = ERR_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                            n_state = S_FLUSH;
                        end
                        CLS_CLOSE: begin
                            if (i_status.empty) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_err = ERR_UNMATCHED;
                                n_state        = S_FLUSH;
                            end else if (i_status.top_open) begin
                                o_cmd.pop = 1'b1;
                                n_state   = S_FLUSH;
                            end else begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_sel = SEL_TOP;
                            end
                        end
                        CLS_OP: begin
                            if (!i_status.empty && i_status.top_outranks) begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_sel = SEL_TOP;
                            end else if (i_status.full) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_err = ERR_OVERFLOW;
                                n_state        = S_FLUSH;
                            end else begin
                                o_cmd.push = 1'b1;
                                n_state    = S_FLUSH;
                            end
                        end
                        CLS_NEWLINE: begin
                            if (!i_status.empty) begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_sel = SEL_TOP;
                            end else begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_done = 1'b1;
                                n_state         = S_FLUSH;
                            end
                        end
                        default: begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_err = ERR_BADCHAR;
                            n_state        = S_FLUSH;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.release_last = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLY(a_idle_no_pending, i_clk, i_rst_n, r_state == S_IDLE, !i_status.pend_valid)
    `ASSERT_IMPLY(a_emit_only_in_eval, i_clk, i_rst_n, o_cmd.emit || o_cmd.pop || o_cmd.push,
                  r_state == S_EVAL)

endmodule

FILE: bench/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
    import itp_pkg::*;

    localparam int DEPTH        = DEFAULT_STACK_DEPTH;
    localparam int TOTAL_ITEMS  = 320;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [7:0] DIGIT_0 = "0";
    localparam logic [7:0] UPPER_A = "A";
    localparam logic [7:0] LOWER_A = "a";
    localparam logic [7:0] OPERATORS [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
        logic [1:0] err;
    } t_postfix;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic       has_res;
        t_postfix   res;
    } t_dir_row;

    localparam t_postfix NO_RES = '0;

    // typed rows carry their result, if any; the others go through the predictor
    localparam t_dir_row DIRECTED [23] = '{
        '{CH_CLOSE,   1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b0, ERR_UNMATCHED}},
        '{"#",        1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b0, ERR_BADCHAR}},
        '{CH_NUL,     1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b0, ERR_BADCHAR}},
        '{8'hFF,      1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b0, ERR_BADCHAR}},
        '{"0",        1'b1, 1'b1, '{"0", 1'b1, 1'b0, ERR_NONE}},
        '{"z",        1'b1, 1'b1, '{"z", 1'b1, 1'b0, ERR_NONE}},
        '{CH_SPACE,   1'b1, 1'b0, NO_RES},
        '{CH_NEWLINE, 1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b1, ERR_NONE}},
        '{CH_OPEN,    1'b0, 1'b0, NO_RES},
        '{"a",        1'b0, 1'b0, NO_RES},
        '{CH_PLUS,    1'b0, 1'b0, NO_RES},
        '{"b",        1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,   1'b0, 1'b0, NO_RES},
        '{CH_STAR,    1'b0, 1'b0, NO_RES},
        '{"c",        1'b0, 1'b0, NO_RES},
        '{CH_PERCENT, 1'b0, 1'b0, NO_RES},
        '{"d",        1'b0, 1'b0, NO_RES},
        '{CH_MINUS,   1'b0, 1'b0, NO_RES},
        '{"e",        1'b0, 1'b0, NO_RES},
        '{CH_SLASH,   1'b0, 1'b0, NO_RES},
        '{CH_OPEN,    1'b0, 1'b0, NO_RES},
        '{"f",        1'b0, 1'b0, NO_RES},
        '{CH_NEWLINE, 1'b0, 1'b0, NO_RES}
    };

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = '0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_last;
    logic [2:0] m_user;

    logic [7:0] op_stk [DEPTH];
    int         op_cnt = 0;
    t_postfix   step_q [$];
    t_postfix   postfix_q [$];
    logic [7:0] text_q [$];

    bit calm = 1'b0;
    int stall_left = 0;
    int idle_run = 0;
    int mismatches = 0;
    int chars_sent = 0;
    int results_seen = 0;
    int exprs_seen = 0;
    int err_seen [4] = '{0, 0, 0, 0};

    infix_to_postfix_converter #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),     // in_char
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),     // out_char
        .o_m_axis_tlast(m_last),
        .o_m_axis_tuser(m_user)      // done_res, error[1:0]
    );

    always #5 i_clk = ~i_clk;

    function automatic int precedence(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) begin
            return 2;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PERCENT) begin
            return 3;
        end
        return 1;
    endfunction

    function automatic bit is_operand(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_operator(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_PERCENT;
    endfunction

    function automatic t_postfix result(input logic [7:0] ch, input logic done,
                                        input logic [1:0] err);
        t_postfix r;
        r = '{ch, 1'b0, done, err};
        return r;
    endfunction

    task automatic push_op(input logic [7:0] c);
        if (op_cnt >= DEPTH) begin
            step_q.push_back(result(CH_NUL, 1'b0, ERR_OVERFLOW));
        end else begin
            op_stk[op_cnt] = c;
            op_cnt++;
        end
    endtask

    // shunting-yard step: fills step_q with what one character releases
    task automatic shunt_char(input logic [7:0] c);
        bit       matched;
        t_postfix r;
        step_q.delete();
        if (c == CH_SPACE) begin
        end else if (is_operand(c)) begin
            step_q.push_back(result(c, 1'b0, ERR_NONE));
        end else if (c == CH_OPEN) begin
            push_op(c);
        end else if (c == CH_CLOSE) begin
            matched = 1'b0;
            while (op_cnt > 0 && !matched) begin
                op_cnt--;
                if (op_stk[op_cnt] == CH_OPEN) begin
                    matched = 1'b1;
                end else begin
                    step_q.push_back(result(op_stk[op_cnt], 1'b0, ERR_NONE));
                end
            end
            if (!matched) begin
                step_q.push_back(result(CH_NUL, 1'b0, ERR_UNMATCHED));
            end
        end else if (is_operator(c)) begin
            while (op_cnt > 0 && precedence(op_stk[op_cnt - 1]) >= precedence(c)) begin
                op_cnt--;
                step_q.push_back(result(op_stk[op_cnt], 1'b0, ERR_NONE));
            end
            push_op(c);
        end else if (c == CH_NEWLINE) begin
            while (op_cnt > 0) begin
                op_cnt--;
                step_q.push_back(result(op_stk[op_cnt], 1'b0, ERR_NONE));
            end
            step_q.push_back(result(CH_NUL, 1'b1, ERR_NONE));
        end else begin
            step_q.push_back(result(CH_NUL, 1'b0, ERR_BADCHAR));
        end
        if (step_q.size() > 0) begin
            r = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_char(input logic [7:0] c, input bit typed, input bit has_res,
                             input t_postfix typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge i_clk); while (!s_ready);
        shunt_char(c);
        chars_sent++;
        if (typed) begin
            if (has_res) begin
                postfix_q.push_back(typed_res);
            end
        end else begin
            foreach (step_q[i]) postfix_q.push_back(step_q[i]);
        end
    endtask

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(0, 2))
            0: return DIGIT_0 + 8'($urandom_range(0, 9));
            1: return UPPER_A + 8'($urandom_range(0, 25));
            default: return LOWER_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic add_token(input logic [7:0] c);
        text_q.push_back(c);
        if ($urandom_range(0, 9) == 0) begin
            text_q.push_back(CH_SPACE);
        end
    endtask

    task automatic build_expression();
        int depth;
        int terms;
        depth = 0;
        terms = $urandom_range(1, 7);
        for (int t = 0; t < terms; t++) begin
            while (depth < 6 && $urandom_range(0, 3) == 0) begin
                add_token(CH_OPEN);
                depth++;
            end
            add_token(rand_operand());
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                add_token(CH_CLOSE);
                depth--;
            end
            if (t < terms - 1) begin
                add_token(OPERATORS[$urandom_range(0, 4)]);
            end
        end
        // now and then leave open parentheses for the flush
        if ($urandom_range(0, 4) != 0) begin
            repeat (depth) add_token(CH_CLOSE);
        end
        text_q.push_back(CH_NEWLINE);
    endtask

    task automatic build_deep_nest();
        repeat ($urandom_range(28, 36)) text_q.push_back(CH_OPEN);
        repeat ($urandom_range(1, 3)) begin
            text_q.push_back(rand_operand());
            text_q.push_back(OPERATORS[$urandom_range(0, 4)]);
        end
        text_q.push_back(rand_operand());
        repeat ($urandom_range(0, 3)) text_q.push_back(CH_CLOSE);
        text_q.push_back(CH_NEWLINE);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        t_postfix got;
        t_postfix want;
        got = '{m_data, m_last, m_user[0], m_user[2:1]};
        results_seen++;
        if (got.done) exprs_seen++;
        err_seen[got.err]++;
        if (postfix_q.size() == 0) begin
            report_mismatch("unexpected result", got, 0);
        end else begin
            want = postfix_q.pop_front();
            if (got.ch != want.ch) report_mismatch("out_char", got.ch, want.ch);
            if (got.last != want.last) report_mismatch("tlast", got.last, want.last);
            if (got.done != want.done) report_mismatch("done_res", got.done, want.done);
            if (got.err != want.err) report_mismatch("error", got.err, want.err);
        end
    endtask

    // output side: check each transfer and stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
            if (idle_run >= IDLE_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, postfix_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            send_char(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].has_res,
                      DIRECTED[i].res);
        end

        while (chars_sent < TOTAL_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            text_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_expression();
            end else if (kind < 80) begin
                build_deep_nest();
            end else if (kind < 90) begin
                build_expression();
                // stray close parenthesis or random byte somewhere in the line
                text_q.insert($urandom_range(0, text_q.size() - 1),
                              $urandom_range(0, 1) ? CH_CLOSE : 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            end
            foreach (text_q[i]) begin
                send_char(text_q[i], 1'b0, 1'b0, NO_RES);
            end
        end
        s_valid <= 1'b0;

        while (postfix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d characters, checked %0d postfix results over %0d expressions",
                 chars_sent, results_seen, exprs_seen);
        $display("error results: %0d stack overflow, %0d unmatched close, %0d bad character",
                 err_seen[ERR_OVERFLOW], err_seen[ERR_UNMATCHED], err_seen[ERR_BADCHAR]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_datapath.sv
rtl/itp_controller.sv
rtl/infix_to_postfix_converter.sv
bench/infix_to_postfix_converter_tb.sv
